[hw/rtl/lct_pkg.sv]
// ---------------------------------------------------------------------------
// Li Chao minimum line tree package
// Shared constants, transaction types, node layout and state encoding.
// ---------------------------------------------------------------------------
package lct_pkg;

   localparam int X_BITS     = 10;
   localparam int IDX_W      = X_BITS + 1;
   localparam int NODE_COUNT = 2 ** IDX_W;

   localparam int OP_W    = 2;
   localparam int SLOPE_W = 32;
   localparam int ICPT_W  = 48;
   localparam int QX_W    = 10;
   localparam int MIN_W   = 50;
   localparam int EPOCH_W = 4;

   localparam int CMP_W  = (X_BITS > QX_W) ? X_BITS : QX_W;
   localparam int COEF_W = SLOPE_W + 1;
   localparam int ADD_W  = ICPT_W + 1;
   localparam int PROD_W = COEF_W + CMP_W + 1;
   localparam int SUM_W  = ((PROD_W > ADD_W) ? PROD_W : ADD_W) + 1;

   localparam logic signed [MIN_W-1:0] MIN_POS = {1'b0, {(MIN_W-1){1'b1}}};
   localparam logic signed [MIN_W-1:0] MIN_NEG = {1'b1, {(MIN_W-1){1'b0}}};

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_EVAL,
      ST_DECIDE,
      ST_QACC,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic signed [SLOPE_W-1:0] slope;
      logic signed [ICPT_W-1:0]  intercept;
      logic [QX_W-1:0]           query_x;
   } req_type;

   typedef struct packed {
      logic signed [MIN_W-1:0] min_value;
      logic                    empty_res;
   } rsp_type;

   typedef struct packed {
      logic [EPOCH_W-1:0]        tag;
      logic signed [SLOPE_W-1:0] slope;
      logic signed [ICPT_W-1:0]  intercept;
   } node_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      node_type         data;
   } mem_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } mem_rd_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef;
      logic signed [ADD_W-1:0]  addend;
      logic [CMP_W-1:0]         x0;
      logic [CMP_W-1:0]         x1;
      logic [CMP_W-1:0]         x2;
   } eval_req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum0;
      logic signed [SUM_W-1:0] sum1;
      logic signed [SUM_W-1:0] sum2;
   } eval_res_type;

endpackage

[hw/rtl/lct_node_mem.sv]
// ---------------------------------------------------------------------------
// Li Chao node memory
// Heap-indexed node store with one write port and one registered read port.
// ---------------------------------------------------------------------------
module lct_node_mem import lct_pkg::*; (
   input  logic       clock,
   input  mem_wr_type mem_wr,
   input  mem_rd_type mem_rd,
   output node_type   rd_data
);

   node_type node_mem [NODE_COUNT];
   node_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         node_mem[mem_wr.addr] <= mem_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd.en) begin
         rd_data_ff <= node_mem[mem_rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/lct_eval.sv]
// ---------------------------------------------------------------------------
// Li Chao line evaluator
// Three registered products coef*x with a shared addend, summed on output.
// ---------------------------------------------------------------------------
module lct_eval import lct_pkg::*; (
   input  logic         clock,
   input  eval_req_type eval_req,
   output eval_res_type eval_res
);

   logic signed [PROD_W-1:0] prod0_ff, prod0_in;
   logic signed [PROD_W-1:0] prod1_ff, prod1_in;
   logic signed [PROD_W-1:0] prod2_ff, prod2_in;
   logic signed [ADD_W-1:0]  addend_ff, addend_in;

   always_comb begin
      prod0_in  = $signed(eval_req.coef) * $signed({1'b0, eval_req.x0});
      prod1_in  = $signed(eval_req.coef) * $signed({1'b0, eval_req.x1});
      prod2_in  = $signed(eval_req.coef) * $signed({1'b0, eval_req.x2});
      addend_in = eval_req.addend;
   end

   always_ff @(posedge clock) begin
      prod0_ff  <= prod0_in;
      prod1_ff  <= prod1_in;
      prod2_ff  <= prod2_in;
      addend_ff <= addend_in;
   end

   assign eval_res.sum0 = SUM_W'(prod0_ff) + SUM_W'(addend_ff);
   assign eval_res.sum1 = SUM_W'(prod1_ff) + SUM_W'(addend_ff);
   assign eval_res.sum2 = SUM_W'(prod2_ff) + SUM_W'(addend_ff);

endmodule

[hw/rtl/lct_ctrl.sv]
// ---------------------------------------------------------------------------
// Li Chao tree controller
// Walks the tree one level per pass through ST_EVAL and ST_DECIDE or ST_QACC,
// inserts or accumulates the minimum, handles clears by epoch and sweeps the node tags after reset and on epoch wrap.
// ---------------------------------------------------------------------------
module lct_ctrl import lct_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_type      req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data,
   output mem_wr_type   mem_wr,
   output mem_rd_type   mem_rd,
   input  node_type     rd_data,
   output eval_req_type eval_req,
   input  eval_res_type eval_res
);

   state_type state_ff, state_in;
   logic                      is_query_ff, is_query_in;
   logic signed [SLOPE_W-1:0] cur_m_ff, cur_m_in;
   logic signed [ICPT_W-1:0]  cur_b_ff, cur_b_in;
   logic signed [SLOPE_W-1:0] node_m_ff, node_m_in;
   logic signed [ICPT_W-1:0]  node_b_ff, node_b_in;
   logic [QX_W-1:0]           qx_ff, qx_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [X_BITS-1:0]         lo_ff, lo_in;
   logic [X_BITS-1:0]         hi_ff, hi_in;
   logic signed [SUM_W-1:0]   best_ff, best_in;
   logic                      any_ff, any_in;
   logic [EPOCH_W-1:0]        epoch_ff, epoch_in;
   logic [IDX_W-1:0]          sweep_ff, sweep_in;
   logic                      rsp_strobe_ff, rsp_strobe_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic [X_BITS:0]         mid_sum;
   logic [X_BITS-1:0]       mid;
   logic [CMP_W-1:0]        qx_ext;
   logic [CMP_W-1:0]        mid_ext;
   logic [IDX_W-1:0]        child_l;
   logic [IDX_W-1:0]        child_r;
   logic                    node_hit;
   logic                    at_leaf;
   logic                    bl, bm, bh;
   logic                    ins_left, ins_right;
   logic                    q_left, q_right;
   logic                    take;
   logic                    epoch_wrap;
   logic                    sweep_last;
   logic signed [MIN_W-1:0] sat_val;

   assign accept     = start && (state_ff == ST_IDLE);
   assign busy       = (state_ff != ST_IDLE);
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid        = mid_sum[X_BITS:1];
   assign qx_ext     = CMP_W'(qx_ff);
   assign mid_ext    = CMP_W'(mid);
   assign child_l    = {idx_ff[IDX_W-2:0], 1'b0};
   assign child_r    = {idx_ff[IDX_W-2:0], 1'b1};
   assign node_hit   = (rd_data.tag == epoch_ff);
   assign at_leaf    = (lo_ff >= hi_ff) || idx_ff[IDX_W-1];
   assign bl         = eval_res.sum0[SUM_W-1];
   assign bm         = eval_res.sum1[SUM_W-1];
   assign bh         = eval_res.sum2[SUM_W-1];
   assign ins_left   = (bl != bm);
   assign ins_right  = (bl == bm) && (bh != bm);
   assign q_left     = (qx_ext < mid_ext);
   assign q_right    = (qx_ext > mid_ext);
   assign take       = !any_ff || (eval_res.sum1 < best_ff);
   assign epoch_wrap = &epoch_ff;
   assign sweep_last = (sweep_ff == IDX_W'(NODE_COUNT - 1));

   always_comb begin
      if (best_ff > SUM_W'(MIN_POS)) begin
         sat_val = MIN_POS;
      end else if (best_ff < SUM_W'(MIN_NEG)) begin
         sat_val = MIN_NEG;
      end else begin
         sat_val = best_ff[MIN_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP: begin
            state_in = sweep_last ? ST_IDLE : ST_SWEEP;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_data.operation)
                  OP_INSERT: state_in = ST_EVAL;
                  OP_QUERY:  state_in = ST_EVAL;
                  OP_CLEAR:  state_in = epoch_wrap ? ST_SWEEP : ST_IDLE;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_EVAL: begin
            if (!node_hit) begin
               state_in = is_query_ff ? ST_RESP : ST_IDLE;
            end else begin
               state_in = is_query_ff ? ST_QACC : ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = (!at_leaf && (ins_left || ins_right)) ? ST_EVAL : ST_IDLE;
         end
         ST_QACC: begin
            state_in = (!at_leaf && (q_left || q_right)) ? ST_EVAL : ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      is_query_in   = is_query_ff;
      cur_m_in      = cur_m_ff;
      cur_b_in      = cur_b_ff;
      node_m_in     = node_m_ff;
      node_b_in     = node_b_ff;
      qx_in         = qx_ff;
      idx_in        = idx_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      best_in       = best_ff;
      any_in        = any_ff;
      epoch_in      = epoch_ff;
      sweep_in      = sweep_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;

      mem_wr.en             = 1'b0;
      mem_wr.addr           = idx_ff;
      mem_wr.data.tag       = epoch_ff;
      mem_wr.data.slope     = cur_m_ff;
      mem_wr.data.intercept = cur_b_ff;
      mem_rd.en             = 1'b0;
      mem_rd.addr           = idx_ff;

      if (is_query_ff) begin
         eval_req.coef   = COEF_W'(rd_data.slope);
         eval_req.addend = ADD_W'(rd_data.intercept);
         eval_req.x1     = qx_ext;
      end else begin
         eval_req.coef   = COEF_W'(cur_m_ff) - COEF_W'(rd_data.slope);
         eval_req.addend = ADD_W'(cur_b_ff) - ADD_W'(rd_data.intercept);
         eval_req.x1     = mid_ext;
      end
      eval_req.x0 = CMP_W'(lo_ff);
      eval_req.x2 = CMP_W'(hi_ff);

      case (state_ff)
         ST_SWEEP: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = sweep_ff;
            mem_wr.data = '0;
            sweep_in    = sweep_ff + 1'b1;
            if (sweep_last) begin
               epoch_in = EPOCH_W'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               is_query_in = (req_data.operation == OP_QUERY);
               cur_m_in    = req_data.slope;
               cur_b_in    = req_data.intercept;
               qx_in       = req_data.query_x;
               idx_in      = IDX_W'(1);
               lo_in       = '0;
               hi_in       = '1;
               best_in     = '0;
               any_in      = 1'b0;
               case (req_data.operation)
                  OP_INSERT, OP_QUERY: begin
                     mem_rd.en   = 1'b1;
                     mem_rd.addr = IDX_W'(1);
                  end
                  OP_CLEAR: begin
                     if (epoch_wrap) begin
                        sweep_in = '0;
                     end else begin
                        epoch_in = epoch_ff + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EVAL: begin
            node_m_in = rd_data.slope;
            node_b_in = rd_data.intercept;
            if (!node_hit && !is_query_ff) begin
               mem_wr.en = 1'b1;
            end
         end
         ST_DECIDE: begin
            if (bm) begin
               mem_wr.en = 1'b1;
               cur_m_in  = node_m_ff;
               cur_b_in  = node_b_ff;
            end
            if (!at_leaf) begin
               if (ins_left) begin
                  idx_in      = child_l;
                  hi_in       = mid - 1'b1;
                  mem_rd.en   = 1'b1;
                  mem_rd.addr = child_l;
               end else if (ins_right) begin
                  idx_in      = child_r;
                  lo_in       = mid + 1'b1;
                  mem_rd.en   = 1'b1;
                  mem_rd.addr = child_r;
               end
            end
         end
         ST_QACC: begin
            any_in = 1'b1;
            if (take) begin
               best_in = eval_res.sum1;
            end
            if (!at_leaf) begin
               if (q_left) begin
                  idx_in      = child_l;
                  hi_in       = mid - 1'b1;
                  mem_rd.en   = 1'b1;
                  mem_rd.addr = child_l;
               end else if (q_right) begin
                  idx_in      = child_r;
                  lo_in       = mid + 1'b1;
                  mem_rd.en   = 1'b1;
                  mem_rd.addr = child_r;
               end
            end
         end
         ST_RESP: begin
            rsp_strobe_in         = 1'b1;
            rsp_data_in.empty_res = !any_ff;
            rsp_data_in.min_value = any_ff ? sat_val : '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_ff      <= '0;
         epoch_ff      <= EPOCH_W'(1);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         epoch_ff      <= epoch_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      is_query_ff <= is_query_in;
      cur_m_ff    <= cur_m_in;
      cur_b_ff    <= cur_b_in;
      node_m_ff   <= node_m_in;
      node_b_ff   <= node_b_in;
      qx_ff       <= qx_in;
      idx_ff      <= idx_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      best_ff     <= best_in;
      any_ff      <= any_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

[hw/rtl/li_chao_min_line_tree.sv]
// ---------------------------------------------------------------------------
// Li Chao minimum line tree
// Stores lines in a heap-indexed Li Chao tree and answers minimum queries.
// ---------------------------------------------------------------------------
//  Channel   Ports                        Transfer
//  request   start, busy, req_data        start high while busy is low
//  response  rsp_strobe, rsp_data         one cycle with rsp_strobe high
//
//  An insert or a query walks the tree one level at a time, and a query
//  ends in a response state that registers the response. Each level costs
//  a node memory read and a pass through the registered multipliers. A
//  clear only steps the epoch, except every 15th clear, which sweeps the
//  node tags like reset does. After reset, busy stays high while the tags
//  are swept. Responses cannot be stalled.
// ---------------------------------------------------------------------------
module li_chao_min_line_tree import lct_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   mem_wr_type   mem_wr;
   mem_rd_type   mem_rd;
   node_type     rd_data;
   eval_req_type eval_req;
   eval_res_type eval_res;

   lct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .mem_wr     (mem_wr),
      .mem_rd     (mem_rd),
      .rd_data    (rd_data),
      .eval_req   (eval_req),
      .eval_res   (eval_res)
   );

   lct_node_mem u_node_mem (
      .clock   (clock),
      .mem_wr  (mem_wr),
      .mem_rd  (mem_rd),
      .rd_data (rd_data)
   );

   lct_eval u_eval (
      .clock    (clock),
      .eval_req (eval_req),
      .eval_res (eval_res)
   );

endmodule

[hw/rtl/lct_checker.sv]
// ---------------------------------------------------------------------------
// Li Chao tree port checker
// Checks the timing relations between request and response transactions.
// ---------------------------------------------------------------------------
module lct_checker import lct_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.operation == OP_INSERT ||
                          req_data.operation == OP_QUERY)) |=> busy)
      else $error("insert or query transaction did not raise busy");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("response not at the end of a busy period");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.empty_res) |-> (rsp_data.min_value == '0))
      else $error("empty response carries a nonzero value");

endmodule

bind li_chao_min_line_tree lct_checker u_lct_checker (.*);

[tb/sv/tb_li_chao_min_line_tree.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Li Chao minimum line tree testbench
// Drives insert, query and clear transactions into the tree, keeps its own
// model of the heap-indexed line store, and checks every query response
// field by field against the predicted minimum and empty flag.
// ---------------------------------------------------------------------------
module tb_li_chao_min_line_tree import lct_pkg::*; ();

   localparam int          CLK_HALF      = 6;
   localparam int          RANDOM_ITEMS  = 800;
   localparam int          SETTLE_CYCLES = 64;
   localparam longint      LIMIT_CYCLES  = 600000;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam longint      VALUE_MAX     = 64'sd562949953421311;
   localparam longint      VALUE_MIN     = -64'sd562949953421312;

   typedef struct {
      req_type     req;
      bit          drain;
      int unsigned gap;
   } pending_item_type;

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    start      = 1'b0;
   logic    busy;
   req_type req_data   = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   pending_item_type pending_q[$];
   rsp_type          minima_due[$];

   longint      line_slope [NODE_COUNT];
   longint      line_icpt  [NODE_COUNT];
   bit          line_valid [NODE_COUNT];

   int unsigned gap_left   = 0;
   longint      cycle_count = 0;
   int          mismatches = 0;
   int          n_insert   = 0;
   int          n_query    = 0;
   int          n_clear    = 0;
   int          n_ignored  = 0;
   int          n_checked  = 0;
   int          n_drains   = 0;

   li_chao_min_line_tree DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #CLK_HALF clock = ~clock;

   function automatic longint eval_line(longint m, longint b, logic [31:0] x);
      return m * longint'({32'd0, x}) + b;
   endfunction

   function automatic void tree_insert(longint m, longint b);
      logic [31:0] idx;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] mid;
      bit          bl;
      bit          bm;
      bit          bh;
      longint      tm;
      longint      tb;
      idx = 1;
      lo  = 0;
      hi  = (32'd1 << X_BITS) - 1;
      while (idx < NODE_COUNT) begin
         if (!line_valid[idx]) begin
            line_slope[idx] = m;
            line_icpt[idx]  = b;
            line_valid[idx] = 1'b1;
            return;
         end
         mid = 32'(({32'd0, lo} + {32'd0, hi}) / 2);
         bl = eval_line(m, b, lo) < eval_line(line_slope[idx], line_icpt[idx], lo);
         bm = eval_line(m, b, mid) < eval_line(line_slope[idx], line_icpt[idx], mid);
         bh = eval_line(m, b, hi) < eval_line(line_slope[idx], line_icpt[idx], hi);
         if (bm) begin
            tm = line_slope[idx];
            tb = line_icpt[idx];
            line_slope[idx] = m;
            line_icpt[idx]  = b;
            m = tm;
            b = tb;
         end
         if (lo >= hi) return;
         if (bl != bm) begin
            hi  = mid - 1;
            idx = idx * 2;
         end else if (bh != bm) begin
            lo  = mid + 1;
            idx = idx * 2 + 1;
         end else begin
            return;
         end
      end
   endfunction

   function automatic rsp_type tree_minimum(logic [31:0] x);
      logic [31:0] idx;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] mid;
      longint      v;
      longint      best;
      bit          any;
      rsp_type     r;
      idx  = 1;
      lo   = 0;
      hi   = (32'd1 << X_BITS) - 1;
      best = 0;
      any  = 1'b0;
      while (idx < NODE_COUNT && line_valid[idx]) begin
         v   = eval_line(line_slope[idx], line_icpt[idx], x);
         mid = 32'(({32'd0, lo} + {32'd0, hi}) / 2);
         if (!any || v < best) best = v;
         any = 1'b1;
         if (lo >= hi) break;
         if (x < mid) begin
            hi  = mid - 1;
            idx = idx * 2;
         end else if (x > mid) begin
            lo  = mid + 1;
            idx = idx * 2 + 1;
         end else begin
            break;
         end
      end
      if (best > VALUE_MAX) best = VALUE_MAX;
      if (best < VALUE_MIN) best = VALUE_MIN;
      r.min_value = best[MIN_W-1:0];
      r.empty_res = !any;
      return r;
   endfunction

   function automatic req_type make_req(logic [OP_W-1:0] op, longint s, longint b,
                                        int unsigned x);
      req_type r;
      r.operation = op;
      r.slope     = s[SLOPE_W-1:0];
      r.intercept = b[ICPT_W-1:0];
      r.query_x   = x[QX_W-1:0];
      return r;
   endfunction

   function automatic longint rand_span(longint r);
      return longint'($urandom_range(0, 32'(2 * r))) - r;
   endfunction

   function automatic longint rand_icpt_full();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return longint'(w);
   endfunction

   function automatic int unsigned pick_gap(bit tight);
      int unsigned r;
      if (tight) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type random_line(int style, longint base_slope);
      case (style)
         0: return make_req(OP_INSERT, rand_span(64), rand_span(20000), $urandom);
         1: return make_req(OP_INSERT, rand_span(1 << 20), rand_span(1 << 30), $urandom);
         2: return make_req(OP_INSERT, longint'($urandom), rand_icpt_full(), $urandom);
         3: return make_req(OP_INSERT, base_slope + rand_span(1), rand_span(100), $urandom);
         default: return make_req(OP_INSERT, rand_span(32'h7fff_ffff), rand_icpt_full(),
                                  $urandom);
      endcase
   endfunction

   task automatic queue_item(req_type r, bit tight);
      pending_item_type p;
      p.req   = r;
      p.drain = 1'b0;
      p.gap   = pick_gap(tight);
      pending_q.push_back(p);
   endtask

   task automatic queue_drain();
      pending_item_type p;
      p.req   = '0;
      p.drain = 1'b1;
      p.gap   = 0;
      pending_q.push_back(p);
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH at cycle %0d: %s got %0d expected %0d",
               cycle_count, what, got, want);
      mismatches++;
   endtask

   // The driver issues queued transactions and holds each one until accepted.
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
      end else if (!(start && busy)) begin
         if (gap_left > 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_q.size() == 0) begin
            start <= 1'b0;
         end else if (pending_q[0].drain) begin
            start <= 1'b0;
            if (!start && minima_due.size() == 0) begin
               void'(pending_q.pop_front());
               n_drains++;
            end
         end else begin
            req_data <= pending_q[0].req;
            start    <= 1'b1;
            gap_left <= pending_q[0].gap;
            void'(pending_q.pop_front());
         end
      end
   end

   // The monitor checks responses and updates the predicted line store.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (minima_due.size() == 0) begin
               report_mismatch("unexpected response min_value",
                               longint'($signed(rsp_data.min_value)), 0);
            end else begin
               want = minima_due.pop_front();
               n_checked++;
               if (rsp_data.min_value !== want.min_value)
                  report_mismatch("min_value", longint'($signed(rsp_data.min_value)),
                                  longint'($signed(want.min_value)));
               if (rsp_data.empty_res !== want.empty_res)
                  report_mismatch("empty_res", longint'(rsp_data.empty_res),
                                  longint'(want.empty_res));
            end
         end
         if (start && !busy) begin
            case (req_data.operation)
               OP_INSERT: begin
                  tree_insert(longint'($signed(req_data.slope)),
                              longint'($signed(req_data.intercept)));
                  n_insert++;
               end
               OP_QUERY: begin
                  minima_due.push_back(tree_minimum({22'd0, req_data.query_x}));
                  n_query++;
               end
               OP_CLEAR: begin
                  foreach (line_valid[i]) line_valid[i] = 1'b0;
                  n_clear++;
               end
               default: n_ignored++;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, minima_due.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int          count;
      int          n;
      int          style;
      int unsigned r;
      bit          tight;
      longint      base_slope;

      foreach (line_valid[i]) line_valid[i] = 1'b0;

      queue_item(make_req(OP_QUERY, 0, 0, 0), 1'b0);
      queue_item(make_req(OP_QUERY, -1, -1, 1023), 1'b0);
      queue_item(make_req(OP_UNUSED, -1, -1, 1023), 1'b0);
      queue_item(make_req(OP_INSERT, 32'sh7fff_ffff, 48'sh7fff_ffff_ffff, 0), 1'b0);
      queue_item(make_req(OP_QUERY, 0, 0, 0), 1'b0);
      queue_item(make_req(OP_QUERY, 0, 0, 1023), 1'b0);
      queue_item(make_req(OP_INSERT, -64'sd2147483648, -64'sd140737488355328, 0), 1'b0);
      queue_item(make_req(OP_QUERY, 0, 0, 0), 1'b0);
      queue_item(make_req(OP_QUERY, 0, 0, 1023), 1'b0);
      queue_item(make_req(OP_QUERY, 0, 0, 512), 1'b0);
      queue_item(make_req(OP_INSERT, 0, 0, 0), 1'b0);
      queue_item(make_req(OP_INSERT, 0, 0, 0), 1'b0);
      queue_item(make_req(OP_INSERT, -1, 511, 0), 1'b0);
      queue_item(make_req(OP_INSERT, 1, -512, 0), 1'b0);
      queue_item(make_req(OP_QUERY, 0, 0, 511), 1'b0);
      queue_item(make_req(OP_QUERY, 0, 0, 512), 1'b0);
      queue_item(make_req(OP_QUERY, 0, 0, 1), 1'b0);
      queue_item(make_req(OP_CLEAR, 0, 0, 0), 1'b0);
      queue_item(make_req(OP_QUERY, 0, 0, 300), 1'b0);
      queue_item(make_req(OP_INSERT, 3, -1000, 0), 1'b0);
      queue_item(make_req(OP_QUERY, 0, 0, 1023), 1'b0);
      queue_item(make_req(OP_CLEAR, 0, 0, 0), 1'b1);
      queue_item(make_req(OP_CLEAR, 0, 0, 0), 1'b1);
      queue_item(make_req(OP_INSERT, -7, 7, 0), 1'b1);
      queue_item(make_req(OP_QUERY, 0, 0, 1), 1'b0);
      queue_drain();

      count = 0;
      while (count < RANDOM_ITEMS) begin
         tight      = ($urandom_range(0, 3) == 0);
         style      = $urandom_range(0, 4);
         base_slope = rand_span(1000);
         if ($urandom_range(0, 9) < 7) begin
            queue_item(make_req(OP_CLEAR, longint'($urandom), rand_icpt_full(), $urandom),
                       tight);
            count++;
         end
         n = $urandom_range(4, 60);
         for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               queue_item(random_line(style, base_slope), tight);
               count++;
            end else if (r < 95) begin
               queue_item(make_req(OP_QUERY, longint'($urandom), rand_icpt_full(),
                                   $urandom_range(0, 1023)), tight);
               count++;
            end else if (r < 97) begin
               queue_item(make_req(OP_UNUSED, longint'($urandom), rand_icpt_full(),
                                   $urandom), tight);
            end else begin
               queue_item(make_req(OP_CLEAR, 0, 0, 0), tight);
               count++;
            end
         end
         if ($urandom_range(0, 3) == 0) queue_drain();
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_q.size() != 0 || start || busy || minima_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d inserts, %0d queries, %0d clears and %0d unused codes;",
               n_insert, n_query, n_clear, n_ignored);
      $display("%0d responses checked, %0d drain pauses, %0d cycles.",
               n_checked, n_drains, cycle_count);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
